// File: design/ccprng_pkg.sv
package ccprng_pkg;

    localparam int MaxBurstDefault = 16;
    localparam int BufWords        = 8;
    localparam int NumRegs         = 6;

    typedef enum logic [1:0] {
        OP_RESEED_KEY  = 2'd0,
        OP_RESEED_SEED = 2'd1,
        OP_DRAW        = 2'd2,
        OP_UNUSED      = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_NOT_SEED  = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

    localparam logic [2:0] REG_KEY01 = 3'd0;
    localparam logic [2:0] REG_KEY23 = 3'd1;
    localparam logic [2:0] REG_KEY45 = 3'd2;
    localparam logic [2:0] REG_KEY67 = 3'd3;
    localparam logic [2:0] REG_NONCE = 3'd4;
    localparam logic [2:0] REG_SEED  = 3'd5;

    localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [1:0] opcode;
        logic [4:0] word_count;
    } t_in_item;

    typedef struct packed {
        logic [63:0] random_word;
        logic [1:0]  status;
        logic        last;
    } t_out_item;

    function automatic logic [31:0] sigma(input logic [1:0] i);
        logic [31:0] v;
        case (i)
            2'd0:    v = 32'h61707865;
            2'd1:    v = 32'h3320646e;
            2'd2:    v = 32'h79622d32;
            default: v = 32'h6b206574;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // one full quarter round on a/b/c/d
    function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] ta, tb, tc, td;
        ta = a + b;   td = rotl(d ^ ta, 16);
        tc = c + td;  tb = rotl(b ^ tc, 12);
        ta = ta + tb; td = rotl(td ^ ta, 8);
        tc = tc + td; tb = rotl(tb ^ tc, 7);
        return {ta, tb, tc, td};
    endfunction

endpackage

// File: design/ccprng_mul64.sv
module ccprng_mul64
    import ccprng_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);
    // low 64 bits of a*b from 32x32 partial products, one a cycle
    logic [1:0]  r_step, n_step;
    logic        r_busy, n_busy;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_a, r_b;
    logic [31:0] w_x, w_y;
    logic [63:0] w_pp;

    always_comb begin
        case (r_step)
            2'd0:    begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            2'd1:    begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            default: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
        endcase
        w_pp = 64'(w_x) * 64'(w_y);
        n_step = r_step;
        n_busy = r_busy;
        n_acc  = r_acc;
        if (i_start) begin
            n_step = 2'd0;
            n_busy = 1'b1;
            n_acc  = '0;
        end else if (r_busy) begin
            if (r_step == 2'd0) n_acc = r_acc + w_pp;
            else                n_acc = r_acc + {w_pp[31:0], 32'd0};
            n_step = r_step + 2'd1;
            if (r_step == 2'd2) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_step <= n_step;
        end
        r_acc <= n_acc;
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
    end

    // final sum, valid while o_done, independent of a new start
    assign o_done = r_busy && (r_step == 2'd2);
    assign o_p    = r_acc + {w_pp[31:0], 32'd0};
endmodule

// File: design/chacha20_prng_word_generator_core.sv
// ChaCha20 word generator, 64-bit counter and 64-bit nonce. A reseed from the
// seed runs five splitmix64 outputs on a shared multiplier; a reseed from the
// registers loads the key and nonce in the S_KEYLD state. A draw takes each
// word from the buffer through S_DRAW, S_BUFRD and S_EMIT; an empty buffer costs
// one block: the state memory is loaded, then 80 quarter rounds run (one word
// read or written per cycle), then the feed-forward fills the buffer with eight
// words. The state memory port limits how fast a block is made.
module chacha20_prng_word_generator_core
    import ccprng_pkg::*;
#(
    parameter int MAX_BURST = MaxBurstDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    localparam int CW = $clog2(MAX_BURST + 1);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_KEYLD   = 12'b000000000010,
        S_MIXADD  = 12'b000000000100,
        S_MIX1    = 12'b000000001000,
        S_MIX2    = 12'b000000010000,
        S_DRAW    = 12'b000000100000,
        S_LOAD    = 12'b000001000000,
        S_QR      = 12'b000010000000,
        S_FFRD    = 12'b000100000000,
        S_FF      = 12'b001000000000,
        S_EMIT    = 12'b010000000000,
        S_BUFRD   = 12'b100000000000
    } t_state;

    t_state r_state;

    logic [63:0] r_cfg [NumRegs];
    logic [31:0] r_key [8];
    logic [63:0] r_nonce, r_ctr;
    logic [3:0]  r_pos;
    logic        r_exh, r_seeded;

    // working state, block input and output buffer memories
    logic [31:0] m_x [16];
    logic [31:0] m_in [16];
    logic [63:0] m_buf [BufWords];

    logic [31:0] r_xrd, r_inrd;
    logic [63:0] r_bufrd;

    logic [CW-1:0] r_left;
    logic [6:0]    r_qr;
    logic [2:0]    r_sub;
    logic [4:0]    r_idx;
    logic [31:0]   r_qa, r_qb, r_qc, r_qd;
    logic [2:0]    r_mixn;
    logic [63:0]   r_s;
    logic [31:0]   r_ffw;
    logic          r_ovalid;
    t_out_item     r_odata;

    logic        mul_start, mul_done;
    logic [63:0] mul_a, mul_b, mul_p;

    ccprng_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    // quarter-round word index: round index selects column or diagonal
    function automatic logic [3:0] qidx(input logic [2:0] q, input logic [1:0] k);
        logic [1:0] col;
        col = q[1:0];
        if (q[2]) col = q[1:0] + k;
        return {k, col};
    endfunction

    logic [3:0] w_qaddr;
    assign w_qaddr = qidx(r_qr[2:0], r_sub[1:0]);

    logic w_out_free;
    assign w_out_free = !r_ovalid || i_ready;

    assign o_ready     = (r_state == S_IDLE) && w_out_free;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_data      = r_odata;

    logic [127:0] w_qo;
    assign w_qo = qround(r_qa, r_qb, r_qc, r_xrd);

    logic [63:0] w_mz;
    assign w_mz = r_s + SM_GAMMA;

    // a new output beat is loaded this cycle
    logic w_oset;
    assign w_oset = (r_state == S_IDLE && i_valid && o_ready && i_data.opcode == OP_DRAW
                     && i_data.word_count != 5'd0 && !r_seeded)
                 || (r_state == S_DRAW && w_out_free && r_pos[3] && r_exh)
                 || (r_state == S_EMIT && w_out_free);

    always_comb begin
        mul_start = 1'b0;
        mul_a = '0;
        mul_b = SM_MUL1;
        if (r_state == S_MIXADD) begin
            mul_start = 1'b1;
            mul_a = w_mz ^ (w_mz >> 30);
        end else if (r_state == S_MIX1 && mul_done) begin
            mul_start = 1'b1;
            mul_a = mul_p ^ (mul_p >> 27);
            mul_b = SM_MUL2;
        end
    end

    logic [63:0] w_sm;
    assign w_sm = mul_p ^ (mul_p >> 31);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_seeded <= 1'b0;
            r_exh    <= 1'b0;
            r_pos    <= 4'(BufWords);
            r_ctr    <= '0;
            r_nonce  <= '0;
            for (int i = 0; i < NumRegs; i++) r_cfg[i] <= '0;
            for (int i = 0; i < 8; i++) r_key[i] <= '0;
        end else begin
            if (r_ovalid && i_ready && !w_oset) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready && i_cfg_index < 3'(NumRegs))
                r_cfg[i_cfg_index] <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        case (i_data.opcode)
                            OP_RESEED_KEY: begin
                                r_state <= S_KEYLD;
                            end
                            OP_RESEED_SEED: begin
                                r_s <= r_cfg[REG_SEED];
                                r_mixn <= 3'd0;
                                r_state <= S_MIXADD;
                            end
                            OP_DRAW: begin
                                if (i_data.word_count != 5'd0) begin
                                    if (!r_seeded) begin
                                        r_ovalid <= 1'b1;
                                        r_odata <= '{64'd0, ST_NOT_SEED, 1'b1};
                                    end else begin
                                        if (32'(i_data.word_count) > MAX_BURST)
                                            r_left <= CW'(MAX_BURST);
                                        else
                                            r_left <= CW'(i_data.word_count);
                                        r_state <= S_DRAW;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_KEYLD: begin
                    for (int i = 0; i < 4; i++) begin
                        r_key[2*i]   <= r_cfg[i][31:0];
                        r_key[2*i+1] <= r_cfg[i][63:32];
                    end
                    r_nonce  <= r_cfg[REG_NONCE];
                    r_ctr    <= '0;
                    r_pos    <= 4'(BufWords);
                    r_exh    <= 1'b0;
                    r_seeded <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_MIXADD: begin
                    r_s <= w_mz;
                    r_state <= S_MIX1;
                end
                S_MIX1: begin
                    if (mul_done) r_state <= S_MIX2;
                end
                S_MIX2: begin
                    if (mul_done) begin
                        if (r_mixn == 3'd4) begin
                            r_nonce  <= w_sm;
                            r_ctr    <= '0;
                            r_pos    <= 4'(BufWords);
                            r_exh    <= 1'b0;
                            r_seeded <= 1'b1;
                            r_state  <= S_IDLE;
                        end else begin
                            r_key[{r_mixn[1:0], 1'b0}] <= w_sm[31:0];
                            r_key[{r_mixn[1:0], 1'b1}] <= w_sm[63:32];
                            r_mixn  <= r_mixn + 3'd1;
                            r_state <= S_MIXADD;
                        end
                    end
                end
                S_DRAW: begin
                    if (w_out_free) begin
                        if (r_pos[3]) begin
                            if (r_exh) begin
                                r_ovalid <= 1'b1;
                                r_odata  <= '{64'd0, ST_EXHAUSTED, 1'b1};
                                r_state  <= S_IDLE;
                            end else begin
                                r_idx   <= '0;
                                r_state <= S_LOAD;
                            end
                        end else begin
                            r_state <= S_BUFRD;
                        end
                    end
                end
                S_BUFRD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= '{r_bufrd, ST_OK, (r_left == CW'(1))};
                        r_pos    <= r_pos + 4'd1;
                        r_left   <= r_left - CW'(1);
                        r_state  <= (r_left == CW'(1)) ? S_IDLE : S_DRAW;
                    end
                end
                S_LOAD: begin
                    if (r_idx == 5'd15) begin
                        r_qr <= '0;
                        r_sub <= '0;
                        r_state <= S_QR;
                    end
                    r_idx <= r_idx + 5'd1;
                end
                S_QR: begin
                    // sub 0..3 read a..d, sub 4 computes and writes a back, 5..7 write b..d via r_sub
                    case (r_sub)
                        3'd1: r_qa <= r_xrd;
                        3'd2: r_qb <= r_xrd;
                        3'd3: r_qc <= r_xrd;
                        3'd4: begin
                            {r_qa, r_qb, r_qc, r_qd} <= w_qo;
                        end
                        default: ;
                    endcase
                    if (r_sub == 3'd4) begin
                        r_sub <= 3'd5;
                    end else if (r_sub == 3'd7) begin
                        r_sub <= '0;
                        if (r_qr == 7'd79) begin
                            r_idx <= '0;
                            r_state <= S_FFRD;
                        end
                        r_qr <= r_qr + 7'd1;
                    end else begin
                        r_sub <= r_sub + 3'd1;
                    end
                end
                S_FFRD: begin
                    r_idx <= r_idx + 5'd1;
                    r_state <= S_FF;
                end
                S_FF: begin
                    if (r_idx[0]) r_ffw <= r_xrd + r_inrd;
                    if (r_idx == 5'd16) begin
                        if (&r_ctr) r_exh <= 1'b1;
                        else r_ctr <= r_ctr + 64'd1;
                        r_pos   <= '0;
                        r_state <= S_BUFRD;
                    end else begin
                        r_idx <= r_idx + 5'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // memory accesses
    logic [3:0] w_ldi;
    logic [31:0] w_ldv;
    assign w_ldi = r_idx[3:0];
    always_comb begin
        case (w_ldi[3:2])
            2'd0:    w_ldv = sigma(w_ldi[1:0]);
            2'd1,
            2'd2:    w_ldv = r_key[3'(w_ldi - 4'd4)];
            default: begin
                case (w_ldi[1:0])
                    2'd0:    w_ldv = r_ctr[31:0];
                    2'd1:    w_ldv = r_ctr[63:32];
                    2'd2:    w_ldv = r_nonce[31:0];
                    default: w_ldv = r_nonce[63:32];
                endcase
            end
        endcase
    end

    logic [3:0] w_wbaddr;
    logic [31:0] w_wbval;
    assign w_wbaddr = qidx(r_qr[2:0], 2'(r_sub - 3'd4));
    always_comb begin
        case (r_sub)
            3'd4:    w_wbval = r_qa;
            3'd5:    w_wbval = r_qb;
            3'd6:    w_wbval = r_qc;
            default: w_wbval = r_qd;
        endcase
    end

    logic [3:0] w_ffidx;
    assign w_ffidx = 4'(r_idx - 5'd1);

    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            m_x[w_ldi]  <= w_ldv;
            m_in[w_ldi] <= w_ldv;
        end else if (r_state == S_QR && r_sub >= 3'd5) begin
            m_x[w_wbaddr] <= w_wbval;
        end else if (r_state == S_QR && r_sub == 3'd4) begin
            m_x[w_wbaddr] <= w_qo[127:96];
        end
        if (r_state == S_QR) r_xrd <= m_x[w_qaddr];
        else r_xrd <= m_x[r_idx[3:0]];
        r_inrd <= m_in[r_idx[3:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FF && r_idx[0] == 1'b0 && r_idx != 5'd0)
            m_buf[w_ffidx[3:1]] <= {r_xrd + r_inrd, r_ffw};
        r_bufrd <= m_buf[r_pos[2:0]];
    end
endmodule

// File: design/ccprng_checker.sv
module ccprng_checker
    import ccprng_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_ready,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data,
    input logic      o_cfg_ready
);
    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status != ST_OK |-> o_data.random_word == 64'd0 && o_data.last)
        else $error("status beat carries data");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("output beat changed while stalled");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.status != ST_RSVD)
        else $error("reserved status");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> o_cfg_ready)
        else $error("input taken while busy");
endmodule

bind chacha20_prng_word_generator_core ccprng_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_data      (o_data),
    .o_cfg_ready (o_cfg_ready)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps

import ccprng_pkg::*;

class rng_scoreboard;
    t_out_item   words_due[$];
    int          errors;
    logic [63:0] regs[NumRegs];
    bit   [31:0] key[8];
    bit   [63:0] nonce;
    bit   [63:0] ctr;
    bit   [63:0] blk[BufWords];
    int          pos;
    bit          exhausted;
    bit          seeded;
    bit   [31:0] x[16];

    function new();
        foreach (regs[i]) regs[i] = '0;
        foreach (key[i]) key[i] = '0;
        foreach (blk[i]) blk[i] = '0;
        nonce     = '0;
        ctr       = '0;
        pos       = BufWords;
        exhausted = 0;
        seeded    = 0;
        errors    = 0;
    endfunction

    function void set_reg(int idx, logic [63:0] v);
        regs[idx] = v;
    endfunction

    function int pending();
        return words_due.size();
    endfunction

    function bit [31:0] rot(bit [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function void mix4(int a, int b, int c, int d);
        x[a] += x[b]; x[d] = rot(x[d] ^ x[a], 16);
        x[c] += x[d]; x[b] = rot(x[b] ^ x[c], 12);
        x[a] += x[b]; x[d] = rot(x[d] ^ x[a], 8);
        x[c] += x[d]; x[b] = rot(x[b] ^ x[c], 7);
    endfunction

    function void next_block();
        bit [31:0] init[16];
        init[0] = 32'h61707865;
        init[1] = 32'h3320646e;
        init[2] = 32'h79622d32;
        init[3] = 32'h6b206574;
        for (int i = 0; i < 8; i++) init[4 + i] = key[i];
        init[12] = ctr[31:0];
        init[13] = ctr[63:32];
        init[14] = nonce[31:0];
        init[15] = nonce[63:32];
        x = init;
        for (int r = 0; r < 10; r++) begin
            mix4(0, 4, 8, 12);
            mix4(1, 5, 9, 13);
            mix4(2, 6, 10, 14);
            mix4(3, 7, 11, 15);
            mix4(0, 5, 10, 15);
            mix4(1, 6, 11, 12);
            mix4(2, 7, 8, 13);
            mix4(3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++) x[i] += init[i];
        for (int i = 0; i < BufWords; i++) blk[i] = {x[2 * i + 1], x[2 * i]};
    endfunction

    function bit [63:0] splitmix(ref bit [63:0] s);
        bit [63:0] z;
        s = s + SM_GAMMA;
        z = s;
        z = (z ^ (z >> 30)) * SM_MUL1;
        z = (z ^ (z >> 27)) * SM_MUL2;
        return z ^ (z >> 31);
    endfunction

    function void load_keys(bit [63:0] k[4], bit [63:0] n);
        for (int i = 0; i < 4; i++) begin
            key[2 * i]     = k[i][31:0];
            key[2 * i + 1] = k[i][63:32];
        end
        nonce     = n;
        ctr       = '0;
        pos       = BufWords;
        exhausted = 0;
        seeded    = 1;
    endfunction

    function void push_word(bit [63:0] w, t_status st, bit lst);
        t_out_item e;
        e.random_word = w;
        e.status      = st;
        e.last        = lst;
        words_due.push_back(e);
    endfunction

    function void note_command(t_in_item it);
        bit [63:0] k[4];
        bit [63:0] s;
        int        cnt;
        cnt = it.word_count;
        case (t_opcode'(it.opcode))
            OP_RESEED_KEY: begin
                for (int i = 0; i < 4; i++) k[i] = regs[i];
                load_keys(k, regs[REG_NONCE]);
            end
            OP_RESEED_SEED: begin
                s = regs[REG_SEED];
                for (int i = 0; i < 4; i++) k[i] = splitmix(s);
                load_keys(k, splitmix(s));
            end
            OP_DRAW: begin
                if (cnt == 0) return;
                if (!seeded) begin
                    push_word('0, ST_NOT_SEED, 1);
                    return;
                end
                if (cnt > MaxBurstDefault) cnt = MaxBurstDefault;
                for (int i = 0; i < cnt; i++) begin
                    if (pos >= BufWords) begin
                        if (exhausted) begin
                            push_word('0, ST_EXHAUSTED, 1);
                            return;
                        end
                        next_block();
                        if (ctr == '1) exhausted = 1;
                        else ctr++;
                        pos = 0;
                    end
                    push_word(blk[pos], ST_OK, i + 1 == cnt);
                    pos++;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_word(t_out_item got);
        t_out_item e;
        if (words_due.size() == 0) begin
            $display("%0t: unexpected beat, actual %h", $time, got);
            errors++;
            return;
        end
        e = words_due.pop_front();
        if (got.random_word !== e.random_word) begin
            $display("%0t: random_word expected %h actual %h", $time, e.random_word,
                     got.random_word);
            errors++;
        end
        if (got.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
            errors++;
        end
        if (got.last !== e.last) begin
            $display("%0t: last expected %0d actual %0d", $time, e.last, got.last);
            errors++;
        end
    endfunction
endclass

module testbench;
    import ccprng_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_data;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_out_item   o_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    rng_scoreboard sb;
    int            hold = 0;
    bit            calm;

    chacha20_prng_word_generator_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    // sink side with random stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_word(o_data);
            hold = calm ? 0 : $urandom_range(0, 8);
        end
        @(negedge i_clk);
        if (!i_rst_n) begin
            i_ready <= 0;
        end else if (hold > 0) begin
            hold    = hold - 1;
            i_ready <= 0;
        end else begin
            i_ready <= 1;
        end
    end

    task automatic send_cmd(t_opcode op, logic [4:0] cnt);
        int gap;
        @(negedge i_clk);
        i_valid           <= 1;
        i_data.opcode     <= op;
        i_data.word_count <= cnt;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        sb.note_command('{opcode: op, word_count: cnt});
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid <= 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic load_regs(int style);
        logic [63:0] v;
        for (int r = 0; r < NumRegs; r++) begin
            case (style)
                0:       v = '0;
                1:       v = '1;
                default: v = {$urandom, $urandom};
            endcase
            write_reg(r[2:0], v);
        end
    endtask

    task automatic random_cmd();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            send_cmd(OP_RESEED_KEY, 5'($urandom_range(0, 31)));
        else if (pick < 10)
            send_cmd(OP_RESEED_SEED, 5'($urandom_range(0, 31)));
        else if (pick < 13)
            send_cmd(OP_UNUSED, 5'($urandom_range(0, 31)));
        else if (pick < 16)
            send_cmd(OP_DRAW, 0);
        else if (pick < 28)
            send_cmd(OP_DRAW, 5'($urandom_range(9, 31)));
        else
            send_cmd(OP_DRAW, 5'($urandom_range(1, 8)));
    endtask

    initial begin
        sb          = new();
        calm        = 0;
        i_rst_n     = 0;
        i_valid     = 0;
        i_data      = '0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // not seeded, ignored commands
        send_cmd(OP_DRAW, 1);
        send_cmd(OP_DRAW, 0);
        send_cmd(OP_DRAW, 31);
        send_cmd(OP_UNUSED, 5);
        // all-zero material
        send_cmd(OP_RESEED_KEY, 0);
        send_cmd(OP_DRAW, 16);
        send_cmd(OP_DRAW, 1);
        send_cmd(OP_DRAW, 17);
        send_cmd(OP_RESEED_SEED, 31);
        send_cmd(OP_DRAW, 31);
        drain();
        load_regs(1);
        send_cmd(OP_RESEED_KEY, 10);
        send_cmd(OP_DRAW, 8);
        send_cmd(OP_DRAW, 15);
        send_cmd(OP_RESEED_SEED, 21);
        send_cmd(OP_DRAW, 3);
        send_cmd(OP_DRAW, 0);
        send_cmd(OP_DRAW, 16);
        drain();

        for (int ph = 0; ph < 5; ph++) begin
            load_regs(2);
            calm = (ph == 2);
            send_cmd(ph[0] ? OP_RESEED_SEED : OP_RESEED_KEY, 5'($urandom_range(0, 31)));
            for (int n = 0; n < 100; n++) random_cmd();
            drain();
        end

        calm = 0;
        drain();
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
